### rtl/core/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

    // Default number of entries the queue holds.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Field widths fixed by the transfer format.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // One request transfer.
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [WORD_W-1:0] value;
    } dq_req_t;

    // One result transfer.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
    } dq_result_t;

    // Operation broadcast from the controller to every cell.
    typedef struct packed {
        logic              shift_right;
        logic              shift_left;
        logic              push_rear;
        logic              pop_rear;
        logic [WORD_W-1:0] word;
    } dq_cell_ctrl_t;

endpackage

### rtl/core/double_ended_queue.sv
// Top level of the double-ended queue built as a chain of storage cells.
//
// Usage:
//   A request transfer is taken at a rising edge where start is high and busy is low.
//   The request pushes req.value at the front or rear, or pops the front or rear.
//   Exactly one result follows each request: done is high for one cycle, and
//   result carries the status, empty flag, entry count and front/rear words.
//   The receiver cannot stall; the result is taken at the edge ending that cycle.
// Timing:
//   The cells update at the accepting edge; the result register loads at the next
//   edge and done is shown in the cycle after that.
//   busy is high for one cycle after each transfer, and no new request is taken
//   while it is high; that cycle is spent on the rear-entry select over all cells.
// Overflow and underflow:
//   A push into a full queue or a pop from an empty one changes nothing and
//   reports its status. front_value and rear_value read 0 when the queue is empty.
// Reset:
//   rst_n clears all valid bits, the count, busy and done at once; the queue
//   starts empty and accepts a request in the first cycle after reset.
module double_ended_queue #(
    parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dq_pkg::dq_req_t    req,
    output logic               done,
    output dq_pkg::dq_result_t result
);
    import dq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    dq_result_t            result_reg;
    dq_result_t            result_next;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    dq_cell_ctrl_t         ctrl;

    logic [WORD_W-1:0]     cell_data  [DEPTH];
    logic                  cell_valid [DEPTH];
    logic [WORD_W-1:0]     cell_rear  [DEPTH];
    logic [WORD_W-1:0]     rear_word;

    assign accept   = start && !busy_reg;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the request into a cell operation, the new count and the status.
    always_comb
    begin
        ctrl.shift_right = 1'b0;
        ctrl.shift_left  = 1'b0;
        ctrl.push_rear   = 1'b0;
        ctrl.pop_rear    = 1'b0;
        ctrl.word        = req.value;
        count_next       = count_reg;
        status_next      = status_reg;
        if (accept)
        begin
            status_next = ST_DONE;
            case (req.req_type)
                REQ_PUSH_FRONT, REQ_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.shift_right = (req.req_type == REQ_PUSH_FRONT);
                        ctrl.push_rear   = (req.req_type == REQ_PUSH_REAR);
                        count_next       = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.shift_left = (req.req_type == REQ_POP_FRONT);
                        ctrl.pop_rear   = (req.req_type == REQ_POP_REAR);
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // The chain of cells; the left end is fed by the pushed word.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] l_data;
        logic              l_valid;
        logic [WORD_W-1:0] r_data;
        logic              r_valid;

        if (i == 0)
        begin : g_left_end
            assign l_data  = req.value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_left_link
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_right_end
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_right_link
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_rear[i])
        );
    end

    // Only the rear cell drives a nonzero tap, so an OR gathers the rear word.
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | cell_rear[i];
        end
    end

    // Assemble the result in the cycle after the cells update.
    always_comb
    begin
        result_next             = result_reg;
        result_next.status      = status_reg;
        result_next.is_empty    = is_empty;
        result_next.entry_count = COUNT_W'(count_reg);
        result_next.front_value = cell_valid[0] ? cell_data[0] : '0;
        result_next.rear_value  = rear_word;
        busy_next               = accept;
        done_next               = busy_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/dq_cell.sv
// One storage cell of the queue chain: a word, its valid bit and neighbor hand-off.
module dq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dq_pkg::dq_cell_ctrl_t     ctrl,
    input  logic [dq_pkg::WORD_W-1:0] left_data,
    input  logic                      left_valid,
    input  logic [dq_pkg::WORD_W-1:0] right_data,
    input  logic                      right_valid,
    output logic [dq_pkg::WORD_W-1:0] data,
    output logic                      valid,
    output logic [dq_pkg::WORD_W-1:0] rear_tap
);
    import dq_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;
    logic              is_rear;

    // This cell holds the rear entry when it is valid and its right neighbor is not.
    assign is_rear = valid_reg && !right_valid;

    // Select the next contents from the broadcast operation.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.push_rear && !valid_reg && left_valid)
        begin
            data_next  = ctrl.word;
            valid_next = 1'b1;
        end
        else if (ctrl.pop_rear && is_rear)
        begin
            valid_next = 1'b0;
        end
    end

    // The valid bit is control state and is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The stored word needs no reset; it is masked by the valid bit.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign rear_tap = is_rear ? data_reg : '0;

endmodule

### rtl/core/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input dq_pkg::dq_req_t    req,
    input logic               done,
    input dq_pkg::dq_result_t result
);
    import dq_pkg::*;

    // An accepted transfer makes the block busy for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted request");

    // Each busy cycle is followed by exactly one result strobe and a free port.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result strobe missing after busy cycle");

    // A result is only shown in a cycle that follows a busy one.
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request");

    // An empty queue reports no entries and zero words.
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |-> result.entry_count == '0 &&
            result.front_value == '0 && result.rear_value == '0)
        else $error("empty result carries data");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status == ST_DONE || result.status == ST_OVERFLOW ||
            result.status == ST_UNDERFLOW)
        else $error("undefined status code");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

### dv/double_ended_queue_tb.sv
// Self-checking double-ended queue testbench: directed and random traffic against a predictor.
module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_N   = 1400;

    // A request waiting to be driven, with an optional hold until all outstanding results return.
    typedef struct {
        dq_req_t request;
        bit      drain_first;
    } pending_request_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    dq_req_t    req = '0;
    logic       busy;
    logic       done;
    dq_result_t result;

    pending_request_t request_backlog[$];
    dq_result_t       expected_results[$];

    // Shadow copy of the queue contents.
    logic signed [WORD_W-1:0] model_slots [DEPTH];
    int model_head  = 0;
    int model_count = 0;

    int burst_left   = 1;
    int gap_left     = 0;
    int accepted_n   = 0;
    int retired_n    = 0;
    int idle_cycles  = 0;
    int mismatches   = 0;

    double_ended_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    // Applies one request to the shadow queue and returns the result it should give.
    function automatic dq_result_t predict_deque_result(dq_req_t r);
        dq_result_t res;
        res = '0;
        res.status = ST_DONE;
        case (r.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (model_count >= DEPTH)
                    res.status = ST_OVERFLOW;
                else
                begin
                    if (r.req_type == REQ_PUSH_FRONT)
                    begin
                        model_head = (model_head + DEPTH - 1) % DEPTH;
                        model_slots[model_head] = r.value;
                    end
                    else
                        model_slots[(model_head + model_count) % DEPTH] = r.value;
                    model_count++;
                end
            end
            default:
            begin
                if (model_count == 0)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    if (r.req_type == REQ_POP_FRONT)
                        model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
        endcase
        res.is_empty    = (model_count == 0);
        res.entry_count = COUNT_W'(model_count);
        if (model_count != 0)
        begin
            res.front_value = model_slots[model_head];
            res.rear_value  = model_slots[(model_head + model_count - 1) % DEPTH];
        end
        return res;
    endfunction

    // Draws a word with extra weight on the edges of the signed range.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(logic [REQ_W-1:0] op, logic signed [WORD_W-1:0] word,
                               bit drain_first);
        pending_request_t p;
        p.request.req_type = op;
        p.request.value    = word;
        p.drain_first      = drain_first;
        request_backlog.push_back(p);
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Driver: presents requests in bursts and records the expected result of each transfer.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        pending_request_t nxt;
        logic             present;
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            present = start;
            if (done)
                retired_n++;
            if (start && !busy)
            begin
                expected_results.push_back(predict_deque_result(req));
                accepted_n++;
                present = 1'b0;
            end
            if (!present)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_backlog.size() != 0 &&
                         !(request_backlog[0].drain_first && accepted_n != retired_n))
                begin
                    nxt = request_backlog.pop_front();
                    req <= nxt.request;
                    present = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end
                end
            end
            start <= present;
        end
    end

    // Monitor: samples mid-cycle, compares each result and watches for a hang.
    always @(negedge clk)
    begin : result_monitor
        dq_result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("status", WORD_W'(exp_r.status), WORD_W'(result.status));
                    check_field("is_empty", WORD_W'(exp_r.is_empty), WORD_W'(result.is_empty));
                    check_field("entry_count", WORD_W'(exp_r.entry_count),
                                WORD_W'(result.entry_count));
                    check_field("front_value", exp_r.front_value, result.front_value);
                    check_field("rear_value", exp_r.rear_value, result.rear_value);
                end
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of test.
    initial
    begin
        int mode;
        int run_left;
        logic [REQ_W-1:0] op;

        // Refused pops on the empty queue; the value field must be ignored.
        add_request(REQ_POP_FRONT, 32'sh1234_5678, 1'b0);
        add_request(REQ_POP_REAR, -32'sd1, 1'b0);
        // Extremes of the word range, pushed at both ends and popped back out.
        add_request(REQ_PUSH_FRONT, 32'sh8000_0000, 1'b0);
        add_request(REQ_PUSH_REAR, 32'sh7FFF_FFFF, 1'b0);
        add_request(REQ_POP_FRONT, '0, 1'b0);
        add_request(REQ_POP_REAR, 32'sh5555_5555, 1'b0);
        // Fill to capacity from both ends so the head wraps below zero.
        for (int i = 0; i < DEPTH; i++)
            add_request((i % 2) ? REQ_PUSH_REAR : REQ_PUSH_FRONT,
                        (i == 0) ? -32'sd1 : (i == 1) ? 32'sd0 : pick_word(), 1'b0);
        // Pushes into the full queue are refused at either end.
        add_request(REQ_PUSH_FRONT, 32'sh0BAD_F00D, 1'b0);
        add_request(REQ_PUSH_REAR, 32'sh7FFF_FFFF, 1'b0);

        // Random runs that lean toward filling, toward draining, or neither.
        mode = 0;
        run_left = 0;
        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 2);
                run_left = $urandom_range(10, 40);
            end
            run_left--;
            case (mode)
                0: op = ($urandom_range(0, 9) < 8)
                        ? REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_REAR))
                        : REQ_W'($urandom_range(REQ_POP_FRONT, REQ_POP_REAR));
                1: op = ($urandom_range(0, 9) < 8)
                        ? REQ_W'($urandom_range(REQ_POP_FRONT, REQ_POP_REAR))
                        : REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_REAR));
                default: op = REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_POP_REAR));
            endcase
            add_request(op, pick_word(), (i == 0) || ($urandom_range(0, 99) == 0));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (request_backlog.size() != 0 || start || accepted_n != retired_n);
        repeat (8) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
